// File: rtl/lnpe_pkg.sv
package lnpe_pkg;

    localparam int OP_W      = 8;
    localparam int ARG_W     = 64;
    localparam int ADDR_W    = 64;
    localparam int REG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;
    localparam int DIV_CNT_W = 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 224;
    localparam int M_TUSER_W = 4;

    localparam logic [OP_W-1:0] OPCODE_CEILING = 8'd255;

    // standard opcodes
    localparam logic [OP_W-1:0] OP_EXTENDED         = 8'd0;
    localparam logic [OP_W-1:0] OP_COPY             = 8'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE_PC       = 8'd2;
    localparam logic [OP_W-1:0] OP_ADVANCE_LINE     = 8'd3;
    localparam logic [OP_W-1:0] OP_SET_FILE         = 8'd4;
    localparam logic [OP_W-1:0] OP_SET_COLUMN       = 8'd5;
    localparam logic [OP_W-1:0] OP_NEGATE_STMT      = 8'd6;
    localparam logic [OP_W-1:0] OP_SET_BLOCK_START  = 8'd7;
    localparam logic [OP_W-1:0] OP_CONST_ADD_PC     = 8'd8;
    localparam logic [OP_W-1:0] OP_FIXED_ADVANCE_PC = 8'd9;
    localparam logic [OP_W-1:0] OP_SET_PROL_END     = 8'd10;
    localparam logic [OP_W-1:0] OP_SET_EPILOGUE_BEG = 8'd11;
    localparam logic [OP_W-1:0] OP_SET_ISA          = 8'd12;

    // extended opcodes
    localparam logic [OP_W-1:0] EXT_SEQ_END         = 8'd1;
    localparam logic [OP_W-1:0] EXT_SET_ADDRESS     = 8'd2;
    localparam logic [OP_W-1:0] EXT_SET_DISCRIM     = 8'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_BASE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LN_BASE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LN_SPAN         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INST_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STMT_DEFAULT    = 3'd4;

    localparam logic [CFG_W-1:0] RST_OPCODE_BASE     = 8'd13;
    localparam logic [CFG_W-1:0] RST_LN_BASE         = 8'hFB;
    localparam logic [CFG_W-1:0] RST_LN_SPAN         = 8'd14;
    localparam logic [CFG_W-1:0] RST_MIN_INST_LENGTH = 8'd1;
    localparam logic             RST_STMT_DEFAULT    = 1'b1;

    typedef enum logic [2:0] {
        K_NOP,
        K_SIMPLE,
        K_COPY,
        K_END_SEQ,
        K_ADV_PC,
        K_CONST_PC,
        K_SPECIAL
    } t_kind;

    typedef struct packed {
        logic capture;
        logic exec_simple;
        logic div_start;
        logic div_step;
        logic mul_start;
        logic mul_quot;
        logic add_apply;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  div_last;
        logic  out_free;
    } t_stat;

endpackage

// File: rtl/lnpe_ctrl.sv
module lnpe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lnpe_pkg::t_stat i_stat,
    output lnpe_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_MUL,
        S_ADD,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    lnpe_pkg::K_SIMPLE: begin
                        o_cmd.exec_simple = 1'b1;
                        n_state           = S_IDLE;
                    end
                    lnpe_pkg::K_COPY, lnpe_pkg::K_END_SEQ: begin
                        n_state = S_EMIT;
                    end
                    lnpe_pkg::K_ADV_PC: begin
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_ADD;
                    end
                    lnpe_pkg::K_CONST_PC, lnpe_pkg::K_SPECIAL: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_quot  = 1'b1;
                n_state         = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_apply = 1'b1;
                n_state = (i_stat.kind == lnpe_pkg::K_SPECIAL) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("row loaded while output register still full");

    a_div_then_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_stat.div_last) |=> (r_state == S_MUL))
        else $error("divider finished without scaling step");

endmodule

// File: rtl/lnpe_dp.sv
module lnpe_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lnpe_pkg::t_cmd                      i_cmd,
    output lnpe_pkg::t_stat                     o_stat,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [lnpe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lnpe_pkg::CFG_W-1:0]          i_cfg_data,
    // request
    input  logic [lnpe_pkg::OP_W-1:0]           i_opcode,
    input  logic [lnpe_pkg::OP_W-1:0]           i_ext_opcode,
    input  logic [lnpe_pkg::ARG_W-1:0]          i_operand,
    // row
    output logic                                o_row_valid,
    input  logic                                i_row_ready,
    output logic [lnpe_pkg::ADDR_W-1:0]         o_row_address,
    output logic [lnpe_pkg::REG_W-1:0]          o_row_line,
    output logic [lnpe_pkg::REG_W-1:0]          o_row_file,
    output logic [lnpe_pkg::REG_W-1:0]          o_row_column,
    output logic                                o_row_is_stmt,
    output logic                                o_row_blk_start,
    output logic                                o_row_seq_end,
    output logic                                o_row_prol_end,
    output logic                                o_row_epil_begin,
    output logic [lnpe_pkg::REG_W-1:0]          o_row_isa,
    output logic [lnpe_pkg::REG_W-1:0]          o_row_discriminator
);

    localparam int OP_W   = lnpe_pkg::OP_W;
    localparam int REG_W  = lnpe_pkg::REG_W;
    localparam int ADDR_W = lnpe_pkg::ADDR_W;

    // configuration
    logic [OP_W-1:0] r_opcode_base;
    logic [OP_W-1:0] r_ln_base;
    logic [OP_W-1:0] r_ln_span;
    logic [OP_W-1:0] r_min_inst;
    logic            r_stmt_default;

    // latched request
    logic [OP_W-1:0]           r_op;
    logic [OP_W-1:0]           r_ext;
    logic [lnpe_pkg::ARG_W-1:0] r_arg;

    // row registers
    logic [ADDR_W-1:0] r_address;
    logic [REG_W-1:0]  r_line;
    logic [REG_W-1:0]  r_file;
    logic [REG_W-1:0]  r_column;
    logic              r_is_stmt;
    logic              r_blk_start;
    logic              r_prol_end;
    logic              r_epil_begin;
    logic [REG_W-1:0]  r_isa;
    logic [REG_W-1:0]  r_discriminator;

    // divider
    logic [OP_W-1:0]               r_div_rem;
    logic [OP_W-1:0]               r_div_quo;
    logic [OP_W-1:0]               r_div_dvd;
    logic                          r_div_zero;
    logic [lnpe_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic [ADDR_W-1:0] r_prod;

    // output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_address;
    logic [REG_W-1:0]  r_out_line;
    logic [REG_W-1:0]  r_out_file;
    logic [REG_W-1:0]  r_out_column;
    logic              r_out_is_stmt;
    logic              r_out_blk_start;
    logic              r_out_seq_end;
    logic              r_out_prol_end;
    logic              r_out_epil_begin;
    logic [REG_W-1:0]  r_out_isa;
    logic [REG_W-1:0]  r_out_discriminator;

    lnpe_pkg::t_kind kind;
    logic [OP_W-1:0] div_dividend;
    logic [OP_W:0]   div_cat;
    logic [OP_W+1:0] div_diff;
    logic [OP_W-1:0] quot;
    logic [OP_W-1:0] rem;
    logic [ADDR_W-1:0] mul_a;
    logic [ADDR_W+OP_W-1:0] mul_full;
    logic [REG_W-1:0] line_step;

    always_comb begin
        if (r_op == lnpe_pkg::OP_EXTENDED) begin
            case (r_ext)
                lnpe_pkg::EXT_SEQ_END:      kind = lnpe_pkg::K_END_SEQ;
                lnpe_pkg::EXT_SET_ADDRESS,
                lnpe_pkg::EXT_SET_DISCRIM:  kind = lnpe_pkg::K_SIMPLE;
                default:                    kind = lnpe_pkg::K_NOP;
            endcase
        end else if (r_op >= r_opcode_base) begin
            kind = lnpe_pkg::K_SPECIAL;
        end else begin
            case (r_op) inside
                lnpe_pkg::OP_COPY:         kind = lnpe_pkg::K_COPY;
                lnpe_pkg::OP_ADVANCE_PC:   kind = lnpe_pkg::K_ADV_PC;
                lnpe_pkg::OP_CONST_ADD_PC: kind = lnpe_pkg::K_CONST_PC;
                [lnpe_pkg::OP_ADVANCE_LINE:lnpe_pkg::OP_SET_BLOCK_START],
                [lnpe_pkg::OP_FIXED_ADVANCE_PC:lnpe_pkg::OP_SET_ISA]:
                                           kind = lnpe_pkg::K_SIMPLE;
                default:                   kind = lnpe_pkg::K_NOP;
            endcase
        end
    end

    assign o_stat.kind     = kind;
    assign o_stat.div_last = (r_div_cnt == {lnpe_pkg::DIV_CNT_W{1'b1}});
    assign o_stat.out_free = !r_out_valid || i_row_ready;

    assign div_dividend = (kind == lnpe_pkg::K_SPECIAL)
                        ? r_op - r_opcode_base
                        : lnpe_pkg::OPCODE_CEILING - r_opcode_base;

    // restoring division, one quotient bit per cycle
    assign div_cat  = {r_div_rem, r_div_quo[OP_W-1]};
    assign div_diff = {1'b0, div_cat} - {2'b00, r_ln_span};

    // a zero divisor gives quotient 0 and remainder equal to the dividend
    assign quot = r_div_zero ? '0 : r_div_quo;
    assign rem  = r_div_zero ? r_div_dvd : r_div_rem;

    assign mul_a     = i_cmd.mul_quot ? {{(ADDR_W-OP_W){1'b0}}, quot} : r_arg;
    assign mul_full  = mul_a * r_min_inst;
    assign line_step = {{(REG_W-OP_W){r_ln_base[OP_W-1]}}, r_ln_base}
                     + {{(REG_W-OP_W){1'b0}}, rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode_base  <= lnpe_pkg::RST_OPCODE_BASE;
            r_ln_base      <= lnpe_pkg::RST_LN_BASE;
            r_ln_span      <= lnpe_pkg::RST_LN_SPAN;
            r_min_inst     <= lnpe_pkg::RST_MIN_INST_LENGTH;
            r_stmt_default <= lnpe_pkg::RST_STMT_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lnpe_pkg::CFG_OPCODE_BASE:     r_opcode_base  <= i_cfg_data;
                lnpe_pkg::CFG_LN_BASE:         r_ln_base      <= i_cfg_data;
                lnpe_pkg::CFG_LN_SPAN:         r_ln_span      <= i_cfg_data;
                lnpe_pkg::CFG_MIN_INST_LENGTH: r_min_inst     <= i_cfg_data;
                lnpe_pkg::CFG_STMT_DEFAULT:    r_stmt_default <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_ext <= i_ext_opcode;
            r_arg <= i_operand;
        end
        if (i_cmd.mul_start) begin
            r_prod <= mul_full[ADDR_W-1:0];
        end
        if (i_cmd.div_start) begin
            r_div_rem  <= '0;
            r_div_quo  <= div_dividend;
            r_div_dvd  <= div_dividend;
            r_div_zero <= (r_ln_span == '0);
        end else if (i_cmd.div_step) begin
            if (div_diff[OP_W+1]) begin
                r_div_rem <= div_cat[OP_W-1:0];
                r_div_quo <= {r_div_quo[OP_W-2:0], 1'b0};
            end else begin
                r_div_rem <= div_diff[OP_W-1:0];
                r_div_quo <= {r_div_quo[OP_W-2:0], 1'b1};
            end
        end
        if (i_cmd.emit) begin
            r_out_address       <= r_address;
            r_out_line          <= r_line;
            r_out_file          <= r_file;
            r_out_column        <= r_column;
            r_out_is_stmt       <= r_is_stmt;
            r_out_blk_start     <= r_blk_start;
            r_out_seq_end       <= (kind == lnpe_pkg::K_END_SEQ);
            r_out_prol_end      <= r_prol_end;
            r_out_epil_begin    <= r_epil_begin;
            r_out_isa           <= r_isa;
            r_out_discriminator <= r_discriminator;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_row_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address       <= '0;
            r_line          <= REG_W'(1);
            r_file          <= REG_W'(1);
            r_column        <= '0;
            r_is_stmt       <= lnpe_pkg::RST_STMT_DEFAULT;
            r_blk_start     <= 1'b0;
            r_prol_end      <= 1'b0;
            r_epil_begin    <= 1'b0;
            r_isa           <= '0;
            r_discriminator <= '0;
        end else if (i_cmd.emit) begin
            if (kind == lnpe_pkg::K_END_SEQ) begin
                r_address <= '0;
                r_line    <= REG_W'(1);
                r_file    <= REG_W'(1);
                r_column  <= '0;
                r_is_stmt <= r_stmt_default;
                r_isa     <= '0;
            end
            r_blk_start     <= 1'b0;
            r_prol_end      <= 1'b0;
            r_epil_begin    <= 1'b0;
            r_discriminator <= '0;
        end else if (i_cmd.add_apply) begin
            r_address <= r_address + r_prod;
            if (kind == lnpe_pkg::K_SPECIAL) begin
                r_line <= r_line + line_step;
            end
        end else if (i_cmd.exec_simple) begin
            if (r_op == lnpe_pkg::OP_EXTENDED) begin
                case (r_ext)
                    lnpe_pkg::EXT_SET_ADDRESS: r_address       <= r_arg;
                    lnpe_pkg::EXT_SET_DISCRIM: r_discriminator <= r_arg[REG_W-1:0];
                    default: ;
                endcase
            end else begin
                case (r_op)
                    lnpe_pkg::OP_ADVANCE_LINE:     r_line  <= r_line + r_arg[REG_W-1:0];
                    lnpe_pkg::OP_SET_FILE:         r_file   <= r_arg[REG_W-1:0];
                    lnpe_pkg::OP_SET_COLUMN:       r_column <= r_arg[REG_W-1:0];
                    lnpe_pkg::OP_NEGATE_STMT:      r_is_stmt <= !r_is_stmt;
                    lnpe_pkg::OP_SET_BLOCK_START:  r_blk_start <= 1'b1;
                    lnpe_pkg::OP_FIXED_ADVANCE_PC:
                        r_address <= r_address + {{(ADDR_W-16){1'b0}}, r_arg[15:0]};
                    lnpe_pkg::OP_SET_PROL_END:     r_prol_end   <= 1'b1;
                    lnpe_pkg::OP_SET_EPILOGUE_BEG: r_epil_begin <= 1'b1;
                    lnpe_pkg::OP_SET_ISA:          r_isa <= r_arg[REG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_row_valid         = r_out_valid;
    assign o_row_address       = r_out_address;
    assign o_row_line          = r_out_line;
    assign o_row_file          = r_out_file;
    assign o_row_column        = r_out_column;
    assign o_row_is_stmt       = r_out_is_stmt;
    assign o_row_blk_start     = r_out_blk_start;
    assign o_row_seq_end       = r_out_seq_end;
    assign o_row_prol_end      = r_out_prol_end;
    assign o_row_epil_begin    = r_out_epil_begin;
    assign o_row_isa           = r_out_isa;
    assign o_row_discriminator = r_out_discriminator;

    a_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && o_stat.div_last && r_ln_span != '0) |=>
        (({8'h00, r_div_quo} * {8'h00, r_ln_span} + {8'h00, r_div_rem})
            == {8'h00, r_div_dvd}) && (r_div_rem < r_ln_span))
        else $error("divider quotient and remainder disagree with dividend");

    a_row_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(i_cmd.emit))
        else $error("row appeared without an emit command");

endmodule

// File: rtl/line_number_program_engine_unit.sv
// Channel   | Dir | Payload
// s_axis    | in  | tdata: opcode[7:0], ext_opcode[15:8], operand[79:16]
// m_axis    | out | tdata: row fields; tuser: row flags; tlast: end of sequence
// cfg       | in  | i_cfg_we, i_cfg_idx, i_cfg_data (8 bits)
//
// One opcode at a time. Set/advance-line style opcodes use decode only; advance_pc
// decode and add; copy and end-of-sequence decode and emit; const_add_pc decode, the
// 8-step restoring divider by the line span, multiply, add; special opcodes also emit.
// A row waits in the output register; the next opcode is accepted meanwhile and
// only a row-emitting opcode stalls on a full output register.
// Reset (synchronous, active low) restores configuration defaults and row registers.
module line_number_program_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // opcode[7:0], ext_opcode[15:8], operand[79:16]
    input  logic [lnpe_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // row_address[63:0], row_line[95:64], row_file[127:96], row_column[159:128],
    // row_isa[191:160], row_discriminator[223:192]
    output logic [lnpe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // row_is_stmt[0], row_blk_start[1], row_prol_end[2], row_epil_begin[3]
    output logic [lnpe_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [lnpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lnpe_pkg::CFG_W-1:0]         i_cfg_data
);

    lnpe_pkg::t_cmd  cmd;
    lnpe_pkg::t_stat stat;

    logic [lnpe_pkg::ADDR_W-1:0] row_address;
    logic [lnpe_pkg::REG_W-1:0]  row_line;
    logic [lnpe_pkg::REG_W-1:0]  row_file;
    logic [lnpe_pkg::REG_W-1:0]  row_column;
    logic [lnpe_pkg::REG_W-1:0]  row_isa;
    logic [lnpe_pkg::REG_W-1:0]  row_discriminator;
    logic                        row_is_stmt;
    logic                        row_blk_start;
    logic                        row_prol_end;
    logic                        row_epil_begin;

    lnpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lnpe_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_opcode            (s_axis_tdata[7:0]),
        .i_ext_opcode        (s_axis_tdata[15:8]),
        .i_operand           (s_axis_tdata[79:16]),
        .o_row_valid         (m_axis_tvalid),
        .i_row_ready         (m_axis_tready),
        .o_row_address       (row_address),
        .o_row_line          (row_line),
        .o_row_file          (row_file),
        .o_row_column        (row_column),
        .o_row_is_stmt       (row_is_stmt),
        .o_row_blk_start     (row_blk_start),
        .o_row_seq_end       (m_axis_tlast),
        .o_row_prol_end      (row_prol_end),
        .o_row_epil_begin    (row_epil_begin),
        .o_row_isa           (row_isa),
        .o_row_discriminator (row_discriminator)
    );

    assign m_axis_tdata = {row_discriminator, row_isa, row_column, row_file,
                           row_line, row_address};
    assign m_axis_tuser = {row_epil_begin, row_prol_end, row_blk_start,
                           row_is_stmt};

endmodule
